// ----- sv/mmt_pkg.sv -----
// Shared types and constants for the matrix multiply with transposes block.
package mmt_pkg;

  // Field widths fixed by the block's interface.
  localparam int unsigned INDEX_WIDTH = 6;
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned SUM_WIDTH   = 35;
  localparam int unsigned POS_WIDTH   = 3;
  localparam int unsigned DIM_WIDTH   = 4;
  localparam int unsigned LAYOUT_WIDTH = 2;
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam int unsigned CFG_DATA_WIDTH  = 4;

  // Load operation codes.
  localparam logic OP_LOAD_X = 1'b0;
  localparam logic OP_LOAD_Y = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_COUNT      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INNER_LENGTH   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COL_COUNT      = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OPERAND_LAYOUT = 3'd3;

  // Operand layout codes; the unused code behaves as the plain product.
  localparam logic [LAYOUT_WIDTH-1:0] LAYOUT_X_Y  = 2'd0;
  localparam logic [LAYOUT_WIDTH-1:0] LAYOUT_X_YT = 2'd1;
  localparam logic [LAYOUT_WIDTH-1:0] LAYOUT_XT_Y = 2'd2;

  // Register reset values.
  localparam logic [DIM_WIDTH-1:0]    DIM_RESET    = 4'd8;
  localparam logic [LAYOUT_WIDTH-1:0] LAYOUT_RESET = LAYOUT_X_Y;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Tag that travels with each multiply-accumulate through the pipeline.
  typedef struct packed {
    logic [POS_WIDTH-1:0] row;
    logic [POS_WIDTH-1:0] col;
    logic                 first_k;
    logic                 final_k;
    logic                 last_result;
  } mac_tag_t;

endpackage

// ----- sv/mmt_if.sv -----
// Load and result channel interfaces with valid/ready handshakes.
interface mmt_load_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       operation;
  logic [mmt_pkg::INDEX_WIDTH-1:0]            element_index;
  logic signed [mmt_pkg::VALUE_WIDTH-1:0]     element_value;
  logic                                       last_element;

  modport source (
    output valid, operation, element_index, element_value, last_element,
    input  ready
  );
  modport sink (
    input  valid, operation, element_index, element_value, last_element,
    output ready
  );
endinterface

interface mmt_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mmt_pkg::SUM_WIDTH-1:0]   product_value;
  logic [mmt_pkg::POS_WIDTH-1:0]          out_row;
  logic [mmt_pkg::POS_WIDTH-1:0]          out_col;
  logic                                   last_result;

  modport source (
    output valid, product_value, out_row, out_col, last_result,
    input  ready
  );
  modport sink (
    input  valid, product_value, out_row, out_col, last_result,
    output ready
  );
endinterface

// ----- sv/mmt_store.sv -----
// Operand store: one write port and one registered read port.
module mmt_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write side.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read side, data registered and held while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/mmt_cell.sv -----
// One cell of the partial-sum chain: holds a sum and passes it to its neighbor.
module mmt_cell #(
  parameter int unsigned W = 35
) (
  input  logic         clk,
  input  logic         shift,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  // Take the neighbor's sum whenever the chain advances.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- sv/matrix_multiply_with_transposes_core.sv -----
// Loads are accepted one per cycle while the sequencer is idle; the product issues one
// multiply-accumulate per cycle unless a waiting result stalls the pipeline. A product of
// m rows, n inner terms and p columns runs through the single multiplier and the chain of
// partial-sum cells, p of them in the sum loop; loads wait until issue ends.
// Reset (synchronous, active high) sets dimensions to 8 and layout to plain; stores keep contents.
module matrix_multiply_with_transposes_core #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  mmt_load_if.sink                               load,
  mmt_result_if.source                           result,
  input  logic                                   cfg_we,
  input  logic [mmt_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [mmt_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned SW    = mmt_pkg::SUM_WIDTH;
  localparam int unsigned PW    = 2 * DATA_WIDTH;

  // Limit a dimension register to the range 1..MAX_DIM.
  function automatic logic [mmt_pkg::DIM_WIDTH-1:0] clamp_dim(
    input logic [mmt_pkg::DIM_WIDTH-1:0] d
  );
    logic [mmt_pkg::DIM_WIDTH-1:0] lim;
    lim = mmt_pkg::DIM_WIDTH'(MAX_DIM);
    if (d == '0) begin
      return mmt_pkg::DIM_WIDTH'(1);
    end else if (d > lim) begin
      return lim;
    end
    return d;
  endfunction

  // Configuration registers.
  logic [mmt_pkg::DIM_WIDTH-1:0]    row_count;
  logic [mmt_pkg::DIM_WIDTH-1:0]    inner_length;
  logic [mmt_pkg::DIM_WIDTH-1:0]    col_count;
  logic [mmt_pkg::LAYOUT_WIDTH-1:0] operand_layout;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= mmt_pkg::DIM_RESET;
      inner_length   <= mmt_pkg::DIM_RESET;
      col_count      <= mmt_pkg::DIM_RESET;
      operand_layout <= mmt_pkg::LAYOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mmt_pkg::REG_ROW_COUNT:      row_count      <= cfg_data;
        mmt_pkg::REG_INNER_LENGTH:   inner_length   <= cfg_data;
        mmt_pkg::REG_COL_COUNT:      col_count      <= cfg_data;
        mmt_pkg::REG_OPERAND_LAYOUT: operand_layout <= mmt_pkg::LAYOUT_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  // Effective dimensions and layout.
  logic [mmt_pkg::DIM_WIDTH-1:0] m_len;
  logic [mmt_pkg::DIM_WIDTH-1:0] n_len;
  logic [mmt_pkg::DIM_WIDTH-1:0] p_len;
  logic [CW-1:0]                 m_last;
  logic [CW-1:0]                 n_last;
  logic [CW-1:0]                 p_last;
  logic                          x_trans;
  logic                          y_trans;

  assign m_len   = clamp_dim(row_count);
  assign n_len   = clamp_dim(inner_length);
  assign p_len   = clamp_dim(col_count);
  assign m_last  = CW'(m_len - mmt_pkg::DIM_WIDTH'(1));
  assign n_last  = CW'(n_len - mmt_pkg::DIM_WIDTH'(1));
  assign p_last  = CW'(p_len - mmt_pkg::DIM_WIDTH'(1));
  assign x_trans = (operand_layout == mmt_pkg::LAYOUT_XT_Y);
  assign y_trans = (operand_layout == mmt_pkg::LAYOUT_X_YT);

  // Sequencer state and loop counters: row i, inner k, column j.
  mmt_pkg::state_t state, state_next;
  logic [CW-1:0]   i_cnt, i_cnt_next;
  logic [CW-1:0]   k_cnt, k_cnt_next;
  logic [CW-1:0]   j_cnt, j_cnt_next;
  logic            adv;
  logic            issue;
  logic            issue_end;
  logic            load_fire;
  logic            start;

  assign load_fire = load.valid && load.ready;
  assign start     = load_fire && (load.operation == mmt_pkg::OP_LOAD_Y) && load.last_element;
  assign issue_end = (i_cnt == m_last) && (k_cnt == n_last) && (j_cnt == p_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmt_pkg::ST_IDLE;
      i_cnt <= '0;
      k_cnt <= '0;
      j_cnt <= '0;
    end else begin
      state <= state_next;
      i_cnt <= i_cnt_next;
      k_cnt <= k_cnt_next;
      j_cnt <= j_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    i_cnt_next = i_cnt;
    k_cnt_next = k_cnt;
    j_cnt_next = j_cnt;
    issue      = 1'b0;
    load.ready = 1'b0;
    case (state)
      mmt_pkg::ST_IDLE: begin
        load.ready = 1'b1;
        if (start) begin
          state_next = mmt_pkg::ST_RUN;
          i_cnt_next = '0;
          k_cnt_next = '0;
          j_cnt_next = '0;
        end
      end
      mmt_pkg::ST_RUN: begin
        issue = 1'b1;
        if (adv) begin
          if (j_cnt == p_last) begin
            j_cnt_next = '0;
            if (k_cnt == n_last) begin
              k_cnt_next = '0;
              if (i_cnt == m_last) begin
                state_next = mmt_pkg::ST_IDLE;
              end else begin
                i_cnt_next = i_cnt + CW'(1);
              end
            end else begin
              k_cnt_next = k_cnt + CW'(1);
            end
          end else begin
            j_cnt_next = j_cnt + CW'(1);
          end
        end
      end
      default: state_next = mmt_pkg::ST_IDLE;
    endcase
  end

  // Operand addresses in each operand's stored layout.
  logic [AW-1:0] x_addr;
  logic [AW-1:0] y_addr;

  always_comb begin
    if (x_trans) begin
      x_addr = AW'(AW'(k_cnt) * AW'(m_len) + AW'(i_cnt));
    end else begin
      x_addr = AW'(AW'(i_cnt) * AW'(n_len) + AW'(k_cnt));
    end
    if (y_trans) begin
      y_addr = AW'(AW'(j_cnt) * AW'(n_len) + AW'(k_cnt));
    end else begin
      y_addr = AW'(AW'(k_cnt) * AW'(p_len) + AW'(j_cnt));
    end
  end

  // Store writes: loads beyond the store are dropped.
  logic                  in_range;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] x_rd;
  logic [DATA_WIDTH-1:0] y_rd;

  assign in_range = ({1'b0, load.element_index} < (mmt_pkg::INDEX_WIDTH + 1)'(DEPTH));
  assign wdata    = DATA_WIDTH'($unsigned(load.element_value));

  mmt_store #(.DEPTH(DEPTH), .AW(AW), .DW(DATA_WIDTH)) u_x_store (
    .clk   (clk),
    .we    (load_fire && in_range && (load.operation == mmt_pkg::OP_LOAD_X)),
    .waddr (load.element_index[AW-1:0]),
    .wdata (wdata),
    .re    (adv),
    .raddr (x_addr),
    .rdata (x_rd)
  );

  mmt_store #(.DEPTH(DEPTH), .AW(AW), .DW(DATA_WIDTH)) u_y_store (
    .clk   (clk),
    .we    (load_fire && in_range && (load.operation == mmt_pkg::OP_LOAD_Y)),
    .waddr (load.element_index[AW-1:0]),
    .wdata (wdata),
    .re    (adv),
    .raddr (y_addr),
    .rdata (y_rd)
  );

  // Tag for the multiply-accumulate issued this cycle.
  mmt_pkg::mac_tag_t issue_tag;

  always_comb begin
    issue_tag.row         = mmt_pkg::POS_WIDTH'(i_cnt);
    issue_tag.col         = mmt_pkg::POS_WIDTH'(j_cnt);
    issue_tag.first_k     = (k_cnt == '0);
    issue_tag.final_k     = (k_cnt == n_last);
    issue_tag.last_result = issue_end;
  end

  // Pipeline control: the whole pipe halts while a result waits unaccepted.
  logic              a_valid;
  logic              b_valid;
  logic              out_valid;
  mmt_pkg::mac_tag_t a_tag;
  mmt_pkg::mac_tag_t b_tag;

  assign adv = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= issue;
      b_valid   <= a_valid;
      out_valid <= b_valid && b_tag.final_k;
    end
  end

  // Multiply stage.
  logic signed [PW-1:0] xy_full;
  logic signed [SW-1:0] b_prod;

  assign xy_full = $signed(x_rd) * $signed(y_rd);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag  <= issue_tag;
      b_tag  <= a_tag;
      b_prod <= SW'(xy_full);
    end
  end

  // Chain of partial-sum cells; the sum for column j returns after p shifts.
  logic [SW-1:0] cell_q [MAX_DIM];
  logic [SW-1:0] acc;
  logic          chain_shift;

  assign chain_shift = adv && b_valid;
  assign acc = (b_tag.first_k ? '0 : cell_q[p_last]) + b_prod;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_chain
    if (c == 0) begin : g_head
      mmt_cell #(.W(SW)) u_cell (
        .clk   (clk),
        .shift (chain_shift),
        .d     (acc),
        .q     (cell_q[c])
      );
    end else begin : g_body
      mmt_cell #(.W(SW)) u_cell (
        .clk   (clk),
        .shift (chain_shift),
        .d     (cell_q[c-1]),
        .q     (cell_q[c])
      );
    end
  end

  // Result register: loaded when the final inner term of an element completes.
  logic signed [SW-1:0]          out_value;
  logic [mmt_pkg::POS_WIDTH-1:0] out_row;
  logic [mmt_pkg::POS_WIDTH-1:0] out_col;
  logic                          out_last;

  always_ff @(posedge clk) begin
    if (adv && b_valid && b_tag.final_k) begin
      out_value <= acc;
      out_row   <= b_tag.row;
      out_col   <= b_tag.col;
      out_last  <= b_tag.last_result;
    end
  end

  assign result.valid         = out_valid;
  assign result.product_value = out_value;
  assign result.out_row       = out_row;
  assign result.out_col       = out_col;
  assign result.last_result   = out_last;

  // Loop counters stay inside the configured dimensions while issuing.
  assert property (@(posedge clk) disable iff (rst)
    (state == mmt_pkg::ST_RUN) |-> (i_cnt <= m_last && k_cnt <= n_last && j_cnt <= p_last))
    else $error("loop counter beyond configured dimension");

  // Issuing the last term of the last element returns the sequencer to idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == mmt_pkg::ST_RUN && adv && issue_end) |=> (state == mmt_pkg::ST_IDLE))
    else $error("sequencer did not finish after last term");

  // A new result only appears after a final inner term left the multiply stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_valid && b_tag.final_k))
    else $error("result raised without a completed sum");

endmodule
